>>> rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock while out of reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/twcr_pkg.sv
package twcr_pkg;

    localparam int SCREEN_HEIGHT = 64;
    localparam int SCREEN_WIDTH  = 640;
    localparam int TEX_SIZE      = 64;
    localparam int NUM_TEXTURES  = 4;
    localparam int STORE_DEPTH   = NUM_TEXTURES * TEX_SIZE * TEX_SIZE;
    localparam int TEX_BITS      = $clog2(TEX_SIZE);
    localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
    localparam logic [23:0] SHADE_MASK = 24'd8355711;

    localparam logic [1:0] CFG_CEILING = 2'd0;
    localparam logic [1:0] CFG_FLOOR   = 2'd1;
    localparam logic [1:0] CFG_PITCH   = 2'd2;
    localparam logic [1:0] CFG_MIRROR  = 2'd3;

    localparam logic [1:0] XCLASS_POS = 2'd1;
    localparam logic [1:0] XCLASS_NEG = 2'd2;

    typedef struct packed {
        logic        action;
        logic [9:0]  column;
        logic        side;
        logic [1:0]  ray_x_class;
        logic        ray_y_negative;
        logic [15:0] wall_frac;
        logic [15:0] wall_height;
        logic [6:0]  span_first;
        logic [6:0]  span_stop;
        logic [13:0] texel_index;
        logic [23:0] texel_color;
    } twcr_in_t;

    typedef struct packed {
        logic [9:0]  pixel_column;
        logic [5:0]  pixel_row;
        logic [23:0] pixel_color;
        logic        last_pixel;
    } twcr_out_t;

    // Render job as it leaves the front end.
    typedef struct packed {
        logic [9:0]          out_col;
        logic                side;
        logic [1:0]          tex;
        logic [TEX_BITS-1:0] tx;
        logic [15:0]         lh;
        logic signed [17:0]  offset;
        logic [6:0]          dstart;
        logic [6:0]          dend;
    } twcr_job_t;

endpackage

>>> rtl/core/twcr_front.sv
module twcr_front import twcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  twcr_in_t    s_data,
    input  logic [7:0]  view_pitch,
    input  logic        mirror_columns,
    output logic        ld_en,
    output logic [ADDR_BITS-1:0] ld_addr,
    output logic [23:0] ld_data,
    output logic        job_valid,
    input  logic        job_ready,
    output twcr_job_t   job
);
    logic      q_valid_reg, q_valid_next;
    twcr_job_t q_reg;
    twcr_job_t cls;
    logic [TEX_BITS+15:0] txp;
    logic [15:0] lh;

    always_comb begin
        lh = (s_data.wall_height == 16'd0) ? 16'd1 : s_data.wall_height;
        cls = '0;
        if (s_data.side == 1'b0) begin
            cls.tex = (s_data.ray_x_class == XCLASS_NEG) ? 2'd2 : 2'd3;
        end else begin
            cls.tex = s_data.ray_y_negative ? 2'd0 : 2'd1;
        end
        txp = {{TEX_BITS{1'b0}}, s_data.wall_frac} * (TEX_BITS+16)'(TEX_SIZE);
        cls.tx = txp[TEX_BITS+15:16];
        if ((!s_data.side && s_data.ray_x_class == XCLASS_POS)
            || (s_data.side && s_data.ray_y_negative)) begin
            cls.tx = TEX_BITS'(TEX_SIZE - 1) - txp[TEX_BITS+15:16];
        end
        cls.side = s_data.side;
        cls.lh = lh;
        cls.offset = $signed({11'd0, s_data.span_first})
                   - 18'($signed(view_pitch))
                   - 18'(SCREEN_HEIGHT / 2)
                   + $signed({3'd0, lh[15:1]});
        cls.out_col = mirror_columns ? 10'(SCREEN_WIDTH - int'(s_data.column))
                                     : s_data.column;
        cls.dstart = s_data.span_first;
        cls.dend = s_data.span_stop;
    end

    // One-entry queue to the back end. A texel load waits until no render is
    // queued or running so it never changes texels an earlier render reads.
    assign s_ready = s_data.action ? (!q_valid_reg || job_ready)
                                   : (!q_valid_reg && job_ready);
    assign job_valid = q_valid_reg;
    assign job = q_reg;
    assign ld_en = s_valid && s_ready && !s_data.action
                   && (32'(s_data.texel_index) < 32'(STORE_DEPTH));
    assign ld_addr = ADDR_BITS'(s_data.texel_index);
    assign ld_data = s_data.texel_color;

    always_comb begin
        q_valid_next = q_valid_reg;
        if (job_valid && job_ready) q_valid_next = 1'b0;
        if (s_valid && s_ready && s_data.action) q_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else begin
            q_valid_reg <= q_valid_next;
        end
        if (s_valid && s_ready && s_data.action) q_reg <= cls;
    end
endmodule

>>> rtl/core/twcr_divider.sv
module twcr_divider import twcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [22:0] quotient
);
    // Restoring divide of TEX_SIZE<<16 by divisor, one bit per cycle.
    localparam logic [22:0] DIVIDEND = 23'(TEX_SIZE) << 16;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] rem_reg;
    logic [22:0] q_reg;
    logic [16:0] trial;
    logic [16:0] sub;

    assign trial = {rem_reg[15:0], DIVIDEND[cnt_reg]};
    assign sub = trial - {1'b0, divisor};
    assign quotient = q_reg;
    assign done = !busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= 5'd22;
            rem_reg <= '0;
            q_reg <= '0;
        end else if (busy_reg) begin
            if (!sub[16]) begin
                rem_reg <= sub;
                q_reg <= {q_reg[21:0], 1'b1};
            end else begin
                rem_reg <= trial;
                q_reg <= {q_reg[21:0], 1'b0};
            end
            if (cnt_reg == 5'd0) busy_reg <= 1'b0;
            else cnt_reg <= cnt_reg - 5'd1;
        end
    end
endmodule

>>> rtl/core/twcr_back.sv
module twcr_back import twcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    output logic        job_ready,
    input  twcr_job_t   job,
    input  logic        ld_en,
    input  logic [ADDR_BITS-1:0] ld_addr,
    input  logic [23:0] ld_data,
    input  logic [23:0] ceiling_color,
    input  logic [23:0] floor_color,
    output logic        m_valid,
    input  logic        m_ready,
    output twcr_out_t   m_data
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_MUL, ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        KIND_CEIL, KIND_TEX, KIND_FLOOR
    } kind_t;

    logic [23:0] mem [STORE_DEPTH];
    logic [23:0] rd_reg;

    state_t      state_reg;
    twcr_job_t   job_reg;
    logic [22:0] step_reg;
    logic signed [47:0] pos_reg;
    logic [6:0]  y_reg;        // row being issued to memory
    logic        div_done;
    logic [22:0] div_q;
    logic        div_go_reg;
    logic        div_wait_reg;

    // pipeline stage: memory read in flight
    logic        p_valid_reg;
    logic [5:0]  p_row_reg;
    kind_t       p_kind_reg;
    logic        o_valid_reg;
    twcr_out_t   o_reg;
    logic        adv;
    logic        stall;
    kind_t       kind;
    logic [TEX_BITS-1:0] ty;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [23:0] tcol;

    twcr_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go_reg),
        .divisor(job_reg.lh), .done(div_done), .quotient(div_q)
    );

    // next job waits until the last row has left the read stage
    assign job_ready = (state_reg == ST_IDLE) && !p_valid_reg;

    // output stage stalls the 2-deep issue pipe
    assign stall = o_valid_reg && !m_ready;
    assign adv = (state_reg == ST_RUN) && !stall && !(p_valid_reg && o_valid_reg && !m_ready);
    assign ty = pos_reg[16+TEX_BITS-1:16];
    assign rd_addr = {job_reg.tex, ty, job_reg.tx};

    always_comb begin
        if (y_reg < job_reg.dstart) kind = KIND_CEIL;
        else if (y_reg < job_reg.dend) kind = KIND_TEX;
        else kind = KIND_FLOOR;
    end

    always_ff @(posedge aclk) begin
        if (ld_en) mem[ld_addr] <= ld_data;
        if (adv) rd_reg <= mem[rd_addr];
    end

    assign tcol = job_reg.side ? ((rd_reg >> 1) & SHADE_MASK) : rd_reg;
    assign m_valid = o_valid_reg;
    assign m_data = o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            div_go_reg <= 1'b0;
            div_wait_reg <= 1'b0;
        end else begin
            div_go_reg <= 1'b0;
            if (o_valid_reg && m_ready) o_valid_reg <= 1'b0;
            if (p_valid_reg && !stall) begin
                o_valid_reg <= 1'b1;
                o_reg.pixel_column <= job_reg.out_col;
                o_reg.pixel_row <= p_row_reg;
                o_reg.last_pixel <= (p_row_reg == 6'(SCREEN_HEIGHT - 1));
                unique case (p_kind_reg)
                    KIND_CEIL: o_reg.pixel_color <= ceiling_color;
                    KIND_TEX:  o_reg.pixel_color <= tcol;
                    default:   o_reg.pixel_color <= floor_color;
                endcase
            end
            if (!stall) p_valid_reg <= adv;
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid && job_ready) begin
                        job_reg <= job;
                        div_go_reg <= 1'b1;
                        div_wait_reg <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    div_wait_reg <= 1'b0;
                    if (!div_wait_reg && !div_go_reg && div_done) begin
                        step_reg <= div_q;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    pos_reg <= 48'($signed(job_reg.offset) * $signed({1'b0, step_reg}));
                    y_reg <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    if (adv) begin
                        p_row_reg <= y_reg[5:0];
                        p_kind_reg <= kind;
                        if (kind == KIND_TEX) pos_reg <= pos_reg + 48'(step_reg);
                        y_reg <= y_reg + 7'd1;
                        if (y_reg == 7'(SCREEN_HEIGHT - 1)) state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/textured_wall_column_renderer.sv
// Textured wall column renderer. Texel loads (action 0) write one entry of a
// 4 x 64 x 64 RGB store and produce nothing; a load is accepted only once no
// render is queued or running, so it never overtakes one. A render (action 1)
// produces exactly 64 pixels, row 0 first, last_pixel on row 63. The front end
// classifies each render (texture pick, column, mirroring, start offset) in
// the accepting cycle and parks it in a one-entry queue. The back end takes a
// job, derives the step from a 23-bit bit-serial division plus start and
// handoff, does the start multiply, then issues one row per cycle while the
// output is taken, and drains its read stage before it takes the next job;
// receiver stalls hold the row loop. Write the configuration only while no
// item is in flight: pitch and mirroring are sampled when a render is
// classified, the colors as each pixel is formed.
`include "assert_macros.svh"
module textured_wall_column_renderer import twcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  twcr_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output twcr_out_t   m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    logic [23:0] ceiling_reg;
    logic [23:0] floor_reg;
    logic [7:0]  pitch_reg;
    logic        mirror_reg;

    logic        ld_en;
    logic [ADDR_BITS-1:0] ld_addr;
    logic [23:0] ld_data;
    logic        job_valid, job_ready;
    twcr_job_t   job;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg <= '0;
            floor_reg <= '0;
            pitch_reg <= '0;
            mirror_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CEILING: ceiling_reg <= cfg_data;
                CFG_FLOOR:   floor_reg <= cfg_data;
                CFG_PITCH:   pitch_reg <= cfg_data[7:0];
                CFG_MIRROR:  mirror_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    twcr_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .view_pitch(pitch_reg), .mirror_columns(mirror_reg),
        .ld_en(ld_en), .ld_addr(ld_addr), .ld_data(ld_data),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    twcr_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .ld_en(ld_en), .ld_addr(ld_addr), .ld_data(ld_data),
        .ceiling_color(ceiling_reg), .floor_color(floor_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // a stalled pixel holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_data), "pixel changed under stall")
    // row 63 is exactly the last pixel
    `ASSERT_IMPL(a_last, aclk, aresetn, m_valid, m_data.last_pixel == (m_data.pixel_row == 6'(SCREEN_HEIGHT - 1)), "last_pixel mismatch")
    // a queued job is never lost while stalled
    `ASSERT_NEXT(a_job_hold, aclk, aresetn, job_valid && !job_ready, job_valid, "queued job dropped")
endmodule
